// ===== rtl/csq_pkg.sv =====
`default_nettype none
package csq_pkg;

  localparam int unsigned AddrW = 4;

  localparam logic [1:0] RegMaxTokens  = 2'd0;
  localparam logic [1:0] RegInitTokens = 2'd1;
  localparam logic [1:0] RegFifoMode   = 2'd2;

  localparam logic [2:0] OpWait    = 3'd0;
  localparam logic [2:0] OpPoll    = 3'd1;
  localparam logic [2:0] OpSignal  = 3'd2;
  localparam logic [2:0] OpCancel  = 3'd3;
  localparam logic [2:0] OpDelete  = 3'd4;
  localparam logic [2:0] OpTimeout = 3'd5;

  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StBusy     = 4'd1;
  localparam logic [3:0] StTimedOut = 4'd2;
  localparam logic [3:0] StInvalid  = 4'd3;
  localparam logic [3:0] StCanceled = 4'd4;
  localparam logic [3:0] StAccess   = 4'd5;
  localparam logic [3:0] StPending  = 4'd6;
  localparam logic [3:0] StNoObject = 4'd7;
  localparam logic [3:0] StFull     = 4'd8;

  typedef struct packed {
    logic [3:0]         id;
    logic signed [31:0] need;
    logic [9:0]         prio;
  } entry_t;

  typedef struct packed {
    logic [3:0] id;
    logic [3:0] status;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/csq_ram.sv =====
`default_nettype none
module csq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/counting_semaphore_wait_queue.sv =====
`default_nettype none
// Channel   | Ports                                    | Handshake
// ----------+------------------------------------------+---------------------------------
// command   | opcode/requester_id/amount/priority_req/ | beat when start_i & !busy_o
//           | zero_timeout                             |
// result    | target_id/status/waiter_total/tokens_now | one beat per cycle with done_o
//           | /last                                    |
// config    | APB psel/penable/pwrite/paddr/pwdata     | write on access phase, pready = 1
//
// Wait, poll and a bad opcode stage their beat on acceptance. Signal, cancel,
// delete and timeout walk the queue RAM at one entry per cycle (no walk when the
// queue is empty); signal, cancel and delete then stage the caller's beat in a final
// state. A priority insert walks from the tail up to its slot. Results are staged in
// a result RAM and played out one per cycle after the walk, because every beat
// carries the final token count. Reset is asynchronous, active low, and needs no
// clearing pass. The receiver cannot stall; busy_o drops as the last beat is read
// out.
module counting_semaphore_wait_queue
  import csq_pkg::*;
#(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [2:0]         opcode_i,
  input  wire logic [3:0]         requester_id_i,
  input  wire logic signed [31:0] amount_i,
  input  wire logic [9:0]         priority_req_i,
  input  wire logic               zero_timeout_i,
  output logic                    done_o,
  output logic [3:0]              target_id_o,
  output logic [3:0]              status_o,
  output logic [4:0]              waiter_total_o,
  output logic signed [31:0]      tokens_now_o,
  output logic                    last_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned QW = $clog2(MAX_WAITERS > 1 ? MAX_WAITERS : 2);
  localparam int unsigned QL = $clog2(MAX_WAITERS + 1);
  localparam int unsigned RD = MAX_WAITERS + 1;
  localparam int unsigned RA = $clog2(RD);
  localparam int unsigned RC = $clog2(RD + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SIG, S_DRAIN, S_TMO, S_INS, S_INS0, S_FIN, S_EMIT
  } state_e;

  // configuration registers
  logic [30:0] max_q, init_q;
  logic        fifo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= 31'd1;
      init_q <= 31'd0;
      fifo_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegMaxTokens:  max_q  <= pwdata[30:0];
        RegInitTokens: init_q <= pwdata[30:0];
        RegFifoMode:   fifo_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegMaxTokens:  prdata = {1'b0, max_q};
      RegInitTokens: prdata = {1'b0, init_q};
      RegFifoMode:   prdata = {31'd0, fifo_q};
      default:       prdata = 32'd0;
    endcase
  end
  assign pready = 1'b1;

  // state
  state_e             state_q, state_d;
  logic signed [31:0] tok_q, tok_d;
  logic [QL-1:0]      len_q, len_d;
  logic               gone_q, gone_d;
  logic [2:0]         op_q, op_d;
  logic [3:0]         id_q, id_d;
  logic signed [31:0] amt_q, amt_d;
  logic [9:0]         prio_q, prio_d;
  logic [4:0]         wt_q, wt_d;
  logic [QL-1:0]      rd_q, rd_d;      // next queue read index
  logic               more_q, more_d;  // tail-down walk still reading
  logic               rv_q, rv_d;      // queue read data valid
  logic [QW-1:0]      p_q, p_d;        // index of entry in read data
  logic [QL-1:0]      w_q, w_d;        // compaction write index
  logic               found_q, found_d;
  logic [RC-1:0]      rcnt_q, rcnt_d;
  logic [RC-1:0]      ek_q, ek_d;
  logic               dv_q, dv_d;
  logic               lst_q, lst_d;

  // queue RAM
  logic          qwe;
  logic [QW-1:0] qwaddr, qraddr;
  entry_t        qwdata, qrdata;

  csq_ram #(.Width($bits(entry_t)), .Depth(MAX_WAITERS)) u_queue (
    .clk_i   (clk_i),
    .we_i    (qwe),
    .waddr_i (qwaddr),
    .wdata_i (qwdata),
    .raddr_i (qraddr),
    .rdata_o (qrdata)
  );

  // result staging RAM
  logic          rwe;
  logic [RA-1:0] rwaddr, rraddr;
  result_t       rwdata, rrdata;

  csq_ram #(.Width($bits(result_t)), .Depth(RD)) u_result (
    .clk_i   (clk_i),
    .we_i    (rwe),
    .waddr_i (rwaddr),
    .wdata_i (rwdata),
    .raddr_i (rraddr),
    .rdata_o (rrdata)
  );

  logic               last_ent;
  logic signed [32:0] sig_sum;
  entry_t             new_ent;

  assign last_ent = rv_q && (QL'(p_q) == len_q - QL'(1));
  assign sig_sum  = {tok_q[31], tok_q} + {amount_i[31], amount_i};
  assign new_ent  = '{id: id_q, need: amt_q, prio: prio_q};

  always_comb begin
    state_d = state_q;  tok_d = tok_q;    len_d = len_q;    gone_d = gone_q;
    op_d = op_q;        id_d = id_q;      amt_d = amt_q;    prio_d = prio_q;
    wt_d = wt_q;        rd_d = rd_q;      more_d = more_q;  rv_d = 1'b0;
    p_d = p_q;          w_d = w_q;        found_d = found_q;
    rcnt_d = rcnt_q;    ek_d = ek_q;      dv_d = 1'b0;      lst_d = 1'b0;
    qwe = 1'b0;  qwaddr = '0;  qwdata = new_ent;  qraddr = rd_q[QW-1:0];
    rwe = 1'b0;  rwaddr = rcnt_q[RA-1:0];  rwdata = '{id: id_q, status: StOk};
    rraddr = ek_q[RA-1:0];

    // forward walks share the read issue
    if (state_q == S_SIG || state_q == S_DRAIN || state_q == S_TMO) begin
      if (rd_q < len_q) begin
        rv_d = 1'b1;
        p_d  = rd_q[QW-1:0];
        rd_d = rd_q + QL'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = opcode_i;  id_d = requester_id_i;  amt_d = amount_i;
          prio_d = priority_req_i;
          wt_d = '0;  rcnt_d = '0;  ek_d = '0;  rd_d = '0;  w_d = '0;
          found_d = 1'b0;
          rwe = 1'b1;  rwaddr = '0;
          rwdata = '{id: requester_id_i, status: StOk};
          rcnt_d = RC'(1);
          state_d = S_EMIT;
          if (gone_q) begin
            rwdata.status = StNoObject;
          end else begin
            unique case (opcode_i)
              OpWait, OpPoll: begin
                if (tok_q >= amount_i) begin
                  tok_d = tok_q - amount_i;
                end else if (opcode_i == OpPoll) begin
                  rwdata.status = StBusy;
                end else if (zero_timeout_i) begin
                  rwdata.status = StTimedOut;
                end else if (len_q >= QL'(MAX_WAITERS)) begin
                  rwdata.status = StFull;
                end else begin
                  rwdata.status = StPending;
                  if (fifo_q || len_q == '0) begin
                    qwe = 1'b1;
                    qwaddr = len_q[QW-1:0];
                    qwdata = '{id: requester_id_i, need: amount_i,
                               prio: fifo_q ? 10'd0 : priority_req_i};
                    len_d = len_q + QL'(1);
                  end else begin
                    rd_d = len_q - QL'(1);
                    more_d = 1'b1;
                    state_d = S_INS;
                  end
                end
              end
              OpSignal: begin
                if (sig_sum > $signed({2'b00, max_q})) begin
                  rwdata.status = StInvalid;
                end else begin
                  tok_d = tok_q + amount_i;
                  rwe = 1'b0;  rcnt_d = '0;
                  state_d = (len_q == '0) ? S_FIN : S_SIG;
                end
              end
              OpCancel, OpDelete: begin
                wt_d = 5'(len_q);
                rwe = 1'b0;  rcnt_d = '0;
                if (len_q == '0) begin
                  len_d = '0;
                  if (opcode_i == OpCancel) begin
                    tok_d = amount_i[31] ? $signed({1'b0, init_q}) : amount_i;
                  end else begin
                    gone_d = 1'b1;
                  end
                  state_d = S_FIN;
                end else begin
                  state_d = S_DRAIN;
                end
              end
              OpTimeout: begin
                rwe = 1'b0;  rcnt_d = '0;
                state_d = (len_q == '0) ? S_IDLE : S_TMO;
              end
              default: rwdata.status = StInvalid;
            endcase
          end
        end
      end

      S_SIG: begin
        if (rv_q) begin
          if (qrdata.need <= tok_q) begin
            tok_d = tok_q - qrdata.need;
            rwe = 1'b1;
            rwdata = '{id: qrdata.id, status: StOk};
            rcnt_d = rcnt_q + RC'(1);
          end else begin
            qwe = 1'b1;
            qwaddr = w_q[QW-1:0];
            qwdata = qrdata;
            w_d = w_q + QL'(1);
          end
          if (last_ent) begin
            len_d = w_d;
            state_d = S_FIN;
          end
        end
      end

      S_DRAIN: begin
        if (rv_q) begin
          rwe = 1'b1;
          rwdata = '{id: qrdata.id, status: (op_q == OpCancel) ? StCanceled : StAccess};
          rcnt_d = rcnt_q + RC'(1);
          if (last_ent) begin
            len_d = '0;
            if (op_q == OpCancel) begin
              tok_d = amt_q[31] ? $signed({1'b0, init_q}) : amt_q;
            end else begin
              gone_d = 1'b1;
            end
            state_d = S_FIN;
          end
        end
      end

      S_TMO: begin
        if (rv_q) begin
          if (found_q) begin
            // close the gap left by the removed waiter
            qwe = 1'b1;
            qwaddr = p_q - QW'(1);
            qwdata = qrdata;
          end else if (qrdata.id == id_q) begin
            found_d = 1'b1;
            rwe = 1'b1;
            rwdata = '{id: id_q, status: StTimedOut};
            rcnt_d = rcnt_q + RC'(1);
          end
          if (last_ent) begin
            if (found_d) begin
              len_d = len_q - QL'(1);
              state_d = S_EMIT;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end

      S_INS: begin
        // walk from the tail, shifting entries up until the slot is found
        qraddr = rd_q[QW-1:0];
        if (more_q) begin
          rv_d = 1'b1;
          p_d = rd_q[QW-1:0];
          if (rd_q == '0) begin
            more_d = 1'b0;
          end else begin
            rd_d = rd_q - QL'(1);
          end
        end
        if (rv_q) begin
          qwe = 1'b1;
          qwaddr = p_q + QW'(1);
          if (qrdata.prio <= prio_q) begin
            qwdata = new_ent;
            len_d = len_q + QL'(1);
            more_d = 1'b0;
            rv_d = 1'b0;
            state_d = S_EMIT;
          end else begin
            qwdata = qrdata;
            if (p_q == '0) begin
              more_d = 1'b0;
              rv_d = 1'b0;
              state_d = S_INS0;
            end
          end
        end
      end

      S_INS0: begin
        qwe = 1'b1;
        qwaddr = '0;
        qwdata = new_ent;
        len_d = len_q + QL'(1);
        state_d = S_EMIT;
      end

      S_FIN: begin
        rwe = 1'b1;
        rwdata = '{id: id_q, status: StOk};
        rcnt_d = rcnt_q + RC'(1);
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (ek_q < rcnt_q) begin
          dv_d = 1'b1;
          lst_d = (ek_q == rcnt_q - RC'(1));
          ek_d = ek_q + RC'(1);
          if (lst_d) begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tok_q   <= '0;
      len_q   <= '0;
      gone_q  <= 1'b0;
      wt_q    <= '0;
      rd_q    <= '0;
      more_q  <= 1'b0;
      rv_q    <= 1'b0;
      p_q     <= '0;
      w_q     <= '0;
      found_q <= 1'b0;
      rcnt_q  <= '0;
      ek_q    <= '0;
      dv_q    <= 1'b0;
      lst_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tok_q   <= tok_d;
      len_q   <= len_d;
      gone_q  <= gone_d;
      wt_q    <= wt_d;
      rd_q    <= rd_d;
      more_q  <= more_d;
      rv_q    <= rv_d;
      p_q     <= p_d;
      w_q     <= w_d;
      found_q <= found_d;
      rcnt_q  <= rcnt_d;
      ek_q    <= ek_d;
      dv_q    <= dv_d;
      lst_q   <= lst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    id_q   <= id_d;
    amt_q  <= amt_d;
    prio_q <= prio_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = dv_q;
  assign target_id_o    = rrdata.id;
  assign status_o       = rrdata.status;
  assign waiter_total_o = wt_q;
  assign tokens_now_o   = tok_q;
  assign last_o         = dv_q & lst_q;

endmodule
`default_nettype wire
